>>> hdl/hfe_pkg.sv
// Shared types and constants for the histogram fill engine.
// Used by the channel interfaces, the controller, the datapath and the top level.
package hfe_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int BINSEL_W   = 8;
  localparam int BCNT_W     = 9;
  localparam int CNT_W      = 32;
  localparam int SUM_W      = 49;
  localparam int SQ_W       = 63;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_STEPS  = 9;
  localparam int DIV_CNT_W  = 4;
  localparam int MUL_W      = SAMPLE_W + BCNT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_EDGE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_EDGE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_FILLED  = 3'd0,
    STAT_UNDER   = 3'd1,
    STAT_OVER    = 3'd2,
    STAT_READ    = 3'd3,
    STAT_INVALID = 3'd4
  } hfe_status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CLASS,
    S_MUL,
    S_DIV,
    S_READ,
    S_COMMIT
  } hfe_state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic classify;
    logic mul;
    logic div_step;
    logic rd;
    logic commit;
  } hfe_cmd_t;

  typedef struct packed {
    logic        clr_last;
    logic        div_last;
    logic        out_free;
    hfe_status_t status;
  } hfe_sts_t;

endpackage

>>> hdl/hfe_if.sv
// Valid/ready channel interfaces for requests, results and register writes.
// Depends on hfe_pkg for field widths.
interface hfe_req_if import hfe_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic signed [SAMPLE_W-1:0] sample;
  logic [BINSEL_W-1:0]        bin_select;

  modport source (output valid, output kind, output sample, output bin_select, input ready);
  modport sink   (input valid, input kind, input sample, input bin_select, output ready);
endinterface

interface hfe_rsp_if import hfe_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [BINSEL_W-1:0]     bin_index;
  logic [CNT_W-1:0]        bin_value;
  logic [CNT_W-1:0]        entry_total;
  logic [CNT_W-1:0]        below_total;
  logic [CNT_W-1:0]        above_total;
  logic signed [SUM_W-1:0] value_sum;
  logic [SQ_W-1:0]         square_sum;

  modport source (output valid, output status, output bin_index, output bin_value,
                  output entry_total, output below_total, output above_total,
                  output value_sum, output square_sum, input ready);
  modport sink   (input valid, input status, input bin_index, input bin_value,
                  input entry_total, input below_total, input above_total,
                  input value_sum, input square_sum, output ready);
endinterface

interface hfe_cfg_if import hfe_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/hfe_ctrl.sv
// Sequencer for the histogram fill engine: clear sweep, classify, divide, read, commit.
// Depends on hfe_pkg for the state, command and status types.
module hfe_ctrl import hfe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  hfe_sts_t sts,
  output hfe_cmd_t cmd
);

  hfe_state_t state;
  hfe_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
        if (req_valid) begin
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd.classify = 1'b1;
        state_next   = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        case (sts.status)
          STAT_FILLED: state_next = S_DIV;
          STAT_READ:   state_next = S_READ;
          default:     state_next = S_COMMIT;
        endcase
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        // Hold here until the output register can take the result.
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

>>> hdl/hfe_datapath.sv
// Datapath: edge registers, bin classification, serial divider, bin count memory,
// saturating totals and the result register. Depends on hfe_pkg and hfe_if.
module hfe_datapath import hfe_pkg::*; #(
  parameter int MAX_BINS = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  hfe_cmd_t                   cmd,
  output hfe_sts_t                   sts,
  input  logic                       req_kind,
  input  logic signed [SAMPLE_W-1:0] req_sample,
  input  logic [BINSEL_W-1:0]        req_bin_select,
  hfe_cfg_if.sink                    cfg,
  hfe_rsp_if.source                  rsp
);

  localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int BIN_LIMIT = (1 << BCNT_W) - 1;
  localparam int BIN_CAP = (MAX_BINS < BIN_LIMIT) ? MAX_BINS : BIN_LIMIT;
  localparam logic [BCNT_W-1:0] BIN_CAP_V = BCNT_W'(BIN_CAP);
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_BINS - 1);

  // Configuration registers.
  logic signed [SAMPLE_W-1:0] low_edge;
  logic signed [SAMPLE_W-1:0] high_edge;
  logic [BCNT_W-1:0]          bin_count;
  logic [BCNT_W-1:0]          bins_act;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_edge  <= '0;
      high_edge <= SAMPLE_W'(256);
      bin_count <= BCNT_W'(256);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_LOW_EDGE:  low_edge  <= cfg.data;
        CFG_HIGH_EDGE: high_edge <= cfg.data;
        CFG_BIN_COUNT: bin_count <= cfg.data[BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (bin_count == '0) begin
      bins_act = BCNT_W'(1);
    end else if (bin_count > BIN_CAP_V) begin
      bins_act = BIN_CAP_V;
    end else begin
      bins_act = bin_count;
    end
  end

  // Captured request.
  logic                       kind_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [BINSEL_W-1:0]        sel_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q   <= req_kind;
      sample_q <= req_sample;
      sel_q    <= req_bin_select;
    end
  end

  // Classification stage.
  hfe_status_t                  status_q;
  hfe_status_t                  status_c;
  logic [SAMPLE_W-1:0]          off_q;
  logic [SAMPLE_W-1:0]          span_q;
  logic [BCNT_W-1:0]            bins_q;
  logic [2*SAMPLE_W-1:0]        sq_q;
  logic signed [SAMPLE_W:0]     off_full;
  logic signed [SAMPLE_W:0]     span_full;
  logic signed [2*SAMPLE_W-1:0] sq_full;

  assign off_full  = (SAMPLE_W+1)'(sample_q) - (SAMPLE_W+1)'(low_edge);
  assign span_full = (SAMPLE_W+1)'(high_edge) - (SAMPLE_W+1)'(low_edge);
  assign sq_full   = (2*SAMPLE_W)'(sample_q) * (2*SAMPLE_W)'(sample_q);

  always_comb begin
    if (kind_q) begin
      status_c = ({1'b0, sel_q} < bins_act) ? STAT_READ : STAT_INVALID;
    end else if (sample_q < low_edge) begin
      status_c = STAT_UNDER;
    end else if (sample_q >= high_edge) begin
      status_c = STAT_OVER;
    end else begin
      status_c = STAT_FILLED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_q <= STAT_INVALID;
    end else if (cmd.classify) begin
      status_q <= status_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.classify) begin
      off_q  <= off_full[SAMPLE_W-1:0];
      span_q <= span_full[SAMPLE_W-1:0];
      bins_q <= bins_act;
      sq_q   <= sq_full;
    end
  end

  // Restoring divider. The offset is below the span, so the quotient
  // fits in the bin count width and the upper product bits start below the span.
  logic [MUL_W-1:0]     prod;
  logic [SAMPLE_W-1:0]  rem;
  logic [DIV_STEPS-1:0] dq;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [SAMPLE_W:0]    trial;
  logic                 trial_ge;

  assign prod     = MUL_W'(off_q) * MUL_W'(bins_q);
  assign trial    = {rem, dq[DIV_STEPS-1]};
  assign trial_ge = trial >= {1'b0, span_q};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rem     <= prod[MUL_W-1:DIV_STEPS];
      dq      <= prod[DIV_STEPS-1:0];
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= trial_ge ? SAMPLE_W'(trial - {1'b0, span_q}) : trial[SAMPLE_W-1:0];
      dq      <= {dq[DIV_STEPS-2:0], trial_ge};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  // Bin count memory with a clearing sweep after reset.
  logic [CNT_W-1:0]  mem [MAX_BINS];
  logic [CNT_W-1:0]  rd_data;
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     bin_addr;
  logic [AW-1:0]     addr_sel;
  logic [BCNT_W-1:0] bin_last;
  logic [BCNT_W-1:0] quot_cap;
  logic [CNT_W-1:0]  inc;

  assign bin_last = bins_q - BCNT_W'(1);
  assign quot_cap = (dq > bin_last) ? bin_last : dq;
  assign addr_sel = (status_q == STAT_READ) ? AW'(sel_q) : AW'(quot_cap);
  assign inc      = (rd_data == CNT_MAX) ? rd_data : rd_data + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      bin_addr <= addr_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_addr] <= '0;
    end else if (cmd.commit && status_q == STAT_FILLED) begin
      mem[bin_addr] <= inc;
    end
    if (cmd.rd) begin
      rd_data <= mem[addr_sel];
    end
  end

  // Totals.
  logic [CNT_W-1:0]        entries;
  logic [CNT_W-1:0]        underflows;
  logic [CNT_W-1:0]        overflows;
  logic signed [SUM_W-1:0] running_sum;
  logic [SQ_W-1:0]         running_square_sum;

  logic [CNT_W-1:0]        entries_next;
  logic [CNT_W-1:0]        underflows_next;
  logic [CNT_W-1:0]        overflows_next;
  logic signed [SUM_W-1:0] running_sum_next;
  logic [SQ_W-1:0]         running_square_sum_next;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_sat;
  logic [SQ_W:0]           sq_wide;
  logic [SQ_W-1:0]         sq_sat;
  logic [BINSEL_W-1:0]     res_idx;
  logic [CNT_W-1:0]        res_val;

  assign sum_wide = (SUM_W+1)'(running_sum) + (SUM_W+1)'(sample_q);
  assign sq_wide  = {1'b0, running_square_sum} + (SQ_W+1)'(sq_q);
  assign sq_sat   = sq_wide[SQ_W] ? {SQ_W{1'b1}} : sq_wide[SQ_W-1:0];

  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  always_comb begin
    entries_next            = entries;
    underflows_next         = underflows;
    overflows_next          = overflows;
    running_sum_next        = running_sum;
    running_square_sum_next = running_square_sum;
    res_idx                 = '0;
    res_val                 = '0;
    case (status_q)
      STAT_FILLED: begin
        entries_next            = (entries == CNT_MAX) ? entries : entries + CNT_W'(1);
        running_sum_next        = sum_sat;
        running_square_sum_next = sq_sat;
        res_idx                 = BINSEL_W'(bin_addr);
        res_val                 = inc;
      end
      STAT_UNDER: begin
        underflows_next = (underflows == CNT_MAX) ? underflows : underflows + CNT_W'(1);
      end
      STAT_OVER: begin
        overflows_next = (overflows == CNT_MAX) ? overflows : overflows + CNT_W'(1);
      end
      STAT_READ: begin
        res_idx = BINSEL_W'(bin_addr);
        res_val = rd_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries            <= '0;
      underflows         <= '0;
      overflows          <= '0;
      running_sum        <= '0;
      running_square_sum <= '0;
    end else if (cmd.commit) begin
      entries            <= entries_next;
      underflows         <= underflows_next;
      overflows          <= overflows_next;
      running_sum        <= running_sum_next;
      running_square_sum <= running_square_sum_next;
    end
  end

  // Result register.
  logic                    out_valid;
  hfe_status_t             out_status;
  logic [BINSEL_W-1:0]     out_idx;
  logic [CNT_W-1:0]        out_val;
  logic [CNT_W-1:0]        out_entries;
  logic [CNT_W-1:0]        out_below;
  logic [CNT_W-1:0]        out_above;
  logic signed [SUM_W-1:0] out_sum;
  logic [SQ_W-1:0]         out_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status  <= status_q;
      out_idx     <= res_idx;
      out_val     <= res_val;
      out_entries <= entries_next;
      out_below   <= underflows_next;
      out_above   <= overflows_next;
      out_sum     <= running_sum_next;
      out_sq      <= running_square_sum_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.bin_index   = out_idx;
  assign rsp.bin_value   = out_val;
  assign rsp.entry_total = out_entries;
  assign rsp.below_total = out_below;
  assign rsp.above_total = out_above;
  assign rsp.value_sum   = out_sum;
  assign rsp.square_sum  = out_sq;

  assign sts.clr_last = (clr_addr == CLR_LAST);
  assign sts.div_last = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign sts.out_free = !out_valid || rsp.ready;
  assign sts.status   = status_q;

endmodule

>>> hdl/histogram_fill_engine_top.sv
// Histogram fill engine, top level. One request at a time; a fill request passes through the
// classify, multiply, divide, read and commit states, the divide done by the nine-step serial
// divider that finds the bin. A bin read skips the divide; an underflow or overflow skips both.
// A finished result waits in the output register while the next request is accepted.
// After reset (rst, synchronous) a sweep over all MAX_BINS addresses zeroes the bin counts;
// no request is accepted during it, register writes are taken at any time.
module histogram_fill_engine_top import hfe_pkg::*; #(
  parameter int MAX_BINS = 256
) (
  input  logic      clk,
  input  logic      rst,
  hfe_req_if.sink   req,
  hfe_rsp_if.source rsp,
  hfe_cfg_if.sink   cfg
);

  hfe_cmd_t cmd;
  hfe_sts_t sts;

  hfe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hfe_datapath #(
    .MAX_BINS (MAX_BINS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .req_kind       (req.kind),
    .req_sample     (req.sample),
    .req_bin_select (req.bin_select),
    .cfg            (cfg),
    .rsp            (rsp)
  );

`ifndef NO_ASSERTIONS
  // A result is only committed when the output register is free.
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!rsp.valid || rsp.ready))
    else $error("result committed over an unread result");

  // A new result appears only after a commit.
  a_rsp_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(cmd.commit))
    else $error("result valid without a commit");

  // After a request is accepted, the engine is busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while busy");

  // Results that touch no bin carry zero index and value.
  a_no_bin_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == STAT_UNDER || rsp.status == STAT_OVER ||
                   rsp.status == STAT_INVALID))
      |-> (rsp.bin_index == '0 && rsp.bin_value == '0))
    else $error("nonzero bin fields on a result without a bin");
`endif

endmodule
